>>> sv/dpse_pkg.sv
// ----------------------------------------------------------------------------
// Dual-porosity solute exchange package
// Shared constants, payload types and helper functions.
// ----------------------------------------------------------------------------
package dpse_pkg;

  localparam int unsigned NumComponentsDef = 4;
  localparam int unsigned NumRegs          = 7;
  localparam int unsigned CfgIdxW          = 3;
  localparam int unsigned CfgDataW         = 31;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegWarrenRoot = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTortuosity = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDepth      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDiff0      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDiff1      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDiff2      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDiff3      = 3'd6;

  localparam logic [30:0] Max31   = 31'h7FFF_FFFF;
  localparam logic [30:0] OneQ16  = 31'h0001_0000;

  typedef struct packed {
    logic signed [31:0] liquid_flux;
    logic signed [31:0] fracture_conc;
    logic signed [31:0] matrix_conc;
    logic [1:0]         component;
    logic [30:0]        time_step;
    logic [30:0]        frac_wc_old;
    logic [30:0]        frac_wc_new;
    logic [30:0]        matrix_wc_old;
    logic [30:0]        matrix_wc_new;
    logic [16:0]        porosity;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] new_fracture_conc;
    logic signed [31:0] new_matrix_conc;
    logic signed [31:0] solute_flux;
    logic               singular_error;
  } out_beat_t;

  // Saturate a signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [95:0] x);
    logic signed [31:0] r;
    if (x > 96'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -96'sh8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Saturate an unsigned value to 31 bits
  function automatic logic [30:0] usat31(input logic [63:0] x);
    return (x > {33'd0, Max31}) ? Max31 : x[30:0];
  endfunction

endpackage

>>> sv/dpse_stream_if.sv
// ----------------------------------------------------------------------------
// Streaming channel
// Valid/ready handshake carrying one payload beat.
// ----------------------------------------------------------------------------
interface dpse_stream_if #(
  parameter int unsigned Width = 32
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/dpse_udiv.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned quotient, BitsPerStage quotient bits per stage, stall aware.
// ----------------------------------------------------------------------------
module dpse_udiv #(
  parameter int unsigned NumW  = 64,
  parameter int unsigned DenW  = 64,
  parameter int unsigned BitsPerStage = 4,
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quot_o,
  output logic [SideW-1:0] side_o
);
  localparam int unsigned NumStages = (NumW + BitsPerStage - 1) / BitsPerStage;
  localparam int unsigned RemW = DenW + 1;

  logic [NumW-1:0]  num_q  [NumStages+1];
  logic [NumW-1:0]  quo_q  [NumStages+1];
  logic [RemW-1:0]  rem_q  [NumStages+1];
  logic [DenW-1:0]  den_q  [NumStages+1];
  logic [SideW-1:0] side_q [NumStages+1];
  logic             vld_q  [NumStages+1];

  assign num_q[0]  = num_i;
  assign quo_q[0]  = '0;
  assign rem_q[0]  = '0;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;
  assign vld_q[0]  = valid_i;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    logic [NumW-1:0] num_d, quo_d;
    logic [RemW-1:0] rem_d;

    // shift in dividend bits and subtract where possible; stop at the last bit
    always_comb begin
      logic [RemW:0] trial;
      num_d = num_q[s];
      quo_d = quo_q[s];
      rem_d = rem_q[s];
      trial = '0;
      for (int b = 0; b < int'(BitsPerStage); b++) begin
        if (s * int'(BitsPerStage) + b < int'(NumW)) begin
          trial = {rem_d, num_d[NumW-1]};
          num_d = {num_d[NumW-2:0], 1'b0};
          if (trial >= {2'b00, den_q[s]}) begin
            trial = trial - {2'b00, den_q[s]};
            quo_d = {quo_d[NumW-2:0], 1'b1};
          end else begin
            quo_d = {quo_d[NumW-2:0], 1'b0};
          end
          rem_d = trial[RemW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1]  <= num_d;
        quo_q[s+1]  <= quo_d;
        rem_q[s+1]  <= rem_d;
        den_q[s+1]  <= den_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[NumStages];
  assign quot_o  = quo_q[NumStages];
  assign side_o  = side_q[NumStages];
endmodule

>>> sv/dpse_omega.sv
// ----------------------------------------------------------------------------
// Exchange coefficient pipeline
// Products and two depth divisions giving omega and omega*dt.
// ----------------------------------------------------------------------------
module dpse_omega #(
  parameter int unsigned NumComponents = dpse_pkg::NumComponentsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  dpse_pkg::in_beat_t  beat_i,
  input  logic [30:0]         wr_coef_i,
  input  logic [30:0]         tort_i,
  input  logic [30:0]         depth_i,
  input  logic [30:0]         diff_i [NumComponents],
  output logic                valid_o,
  output dpse_pkg::in_beat_t  beat_o,
  output logic [30:0]         omega_o,
  output logic [30:0]         omdt_o
);
  localparam int unsigned SideW = $bits(dpse_pkg::in_beat_t);

  logic [30:0] depth_eff;
  assign depth_eff = (depth_i == '0) ? 31'd1 : depth_i;

  // stage 1: warren-root times porosity, select diffusion
  logic               v1_q;
  dpse_pkg::in_beat_t b1_q;
  logic [30:0]        om1_q, diff1_q;
  logic [30:0]        diff_sel;

  always_comb begin
    diff_sel = '0;
    for (int c = 0; c < int'(NumComponents); c++) begin
      if (beat_i.component == c[1:0]) begin
        diff_sel = diff_i[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_q    <= beat_i;
      diff1_q <= diff_sel;
      om1_q   <= dpse_pkg::usat31(({33'd0, wr_coef_i} * {47'd0, beat_i.porosity}) >> 16);
    end
  end

  // stage 2: times tortuosity
  logic               v2_q;
  dpse_pkg::in_beat_t b2_q;
  logic [30:0]        om2_q, diff2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b2_q    <= b1_q;
      diff2_q <= diff1_q;
      om2_q   <= dpse_pkg::usat31(({33'd0, om1_q} * {33'd0, tort_i}) >> 16);
    end
  end

  // stage 3: times diffusion
  logic               v3_q;
  dpse_pkg::in_beat_t b3_q;
  logic [30:0]        om3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b3_q  <= b2_q;
      om3_q <= dpse_pkg::usat31(({33'd0, om2_q} * {33'd0, diff2_q}) >> 16);
    end
  end

  // two divisions by depth; quotient of (a<<16)/d fits in 47 bits
  logic               dv1;
  logic [46:0]        q1;
  dpse_pkg::in_beat_t sd1;
  dpse_udiv #(.NumW(47), .DenW(31), .BitsPerStage(4), .SideW(SideW)) u_div1 (
    .clk_i, .rst_ni, .en_i,
    .valid_i (v3_q),
    .num_i   ({om3_q, 16'd0}),
    .den_i   (depth_eff),
    .side_i  (b3_q),
    .valid_o (dv1),
    .quot_o  (q1),
    .side_o  (sd1)
  );

  logic               dv2;
  logic [46:0]        q2;
  dpse_pkg::in_beat_t sd2;
  dpse_udiv #(.NumW(47), .DenW(31), .BitsPerStage(4), .SideW(SideW)) u_div2 (
    .clk_i, .rst_ni, .en_i,
    .valid_i (dv1),
    .num_i   ({dpse_pkg::usat31({17'd0, q1}), 16'd0}),
    .den_i   (depth_eff),
    .side_i  (sd1),
    .valid_o (dv2),
    .quot_o  (q2),
    .side_o  (sd2)
  );

  // final stage: omega times dt
  logic [30:0] omega;
  assign omega = dpse_pkg::usat31({17'd0, q2});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= dv2;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_o  <= sd2;
      omega_o <= omega;
      omdt_o  <= dpse_pkg::usat31(({33'd0, omega} * {33'd0, sd2.time_step}) >> 16);
    end
  end
endmodule

>>> sv/dpse_solve.sv
// ----------------------------------------------------------------------------
// Implicit 2x2 solver pipeline
// Builds the upwinded system, forms Cramer terms, divides and forms flux.
// ----------------------------------------------------------------------------
module dpse_solve (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  dpse_pkg::in_beat_t  beat_i,
  input  logic [30:0]         omega_i,
  input  logic [30:0]         omdt_i,
  output logic                valid_o,
  output dpse_pkg::out_beat_t beat_o
);
  typedef struct packed {
    logic signed [31:0] flux;
    logic [30:0]        omega;
  } fside_t;

  // stage A: coefficients and right-hand sides
  logic               va_q;
  fside_t             fa_q;
  logic signed [31:0] bf_q, bm_q, a00_q, a11_q, b0_q, b1_q;
  logic signed [31:0] bf_d, bm_d;
  logic signed [32:0] w;
  logic signed [63:0] pf, pm;

  always_comb begin
    w = {2'b00, omdt_i};
    if (beat_i.liquid_flux > 0) begin
      bm_d = w[31:0];
      bf_d = dpse_pkg::sat32(96'(w) + 96'(beat_i.liquid_flux));
    end else begin
      bf_d = w[31:0];
      bm_d = dpse_pkg::sat32(96'(w) - 96'(beat_i.liquid_flux));
    end
    pf = $signed({33'd0, beat_i.frac_wc_old}) * 64'(beat_i.fracture_conc);
    pm = $signed({33'd0, beat_i.matrix_wc_old}) * 64'(beat_i.matrix_conc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fa_q  <= '{flux: beat_i.liquid_flux, omega: omega_i};
      bf_q  <= bf_d;
      bm_q  <= bm_d;
      a00_q <= dpse_pkg::sat32(96'($signed({1'b0, beat_i.frac_wc_new})) + 96'(bf_d));
      a11_q <= dpse_pkg::sat32(96'($signed({1'b0, beat_i.matrix_wc_new})) + 96'(bm_d));
      b0_q  <= dpse_pkg::sat32(96'(pf >>> 16));
      b1_q  <= dpse_pkg::sat32(96'(pm >>> 16));
    end
  end

  // stage B: products
  logic               vb_q;
  fside_t             fb_q;
  logic signed [63:0] p_aa_q, p_bb_q, p_n0a_q, p_n0b_q, p_n1a_q, p_n1b_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fb_q    <= fa_q;
      p_aa_q  <= 64'(a00_q) * 64'(a11_q);
      p_bb_q  <= 64'(bm_q) * 64'(bf_q);
      p_n0a_q <= 64'(b0_q) * 64'(a11_q);
      p_n0b_q <= 64'(bm_q) * 64'(b1_q);
      p_n1a_q <= 64'(a00_q) * 64'(b1_q);
      p_n1b_q <= 64'(bf_q) * 64'(b0_q);
    end
  end

  // stage C: determinant and numerators
  logic               vc_q;
  fside_t             fc_q;
  logic signed [64:0] det_q, n0_q, n1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= vb_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fc_q  <= fb_q;
      det_q <= 65'(p_aa_q) - 65'(p_bb_q);
      n0_q  <= 65'(p_n0a_q) + 65'(p_n0b_q);
      n1_q  <= 65'(p_n1a_q) + 65'(p_n1b_q);
    end
  end

  // stage D: magnitudes and signs
  typedef struct packed {
    fside_t f;
    logic   sing;
    logic   neg0;
    logic   neg1;
  } dside_t;
  localparam int unsigned DSideW = $bits(dside_t);

  logic        vd_q;
  dside_t      sd_q;
  logic [63:0] m0_q, m1_q, den_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= vc_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q.f    <= fc_q;
      sd_q.sing <= (det_q <= 0);
      sd_q.neg0 <= n0_q[64];
      sd_q.neg1 <= n1_q[64];
      m0_q      <= n0_q[64] ? 64'(-n0_q) : n0_q[63:0];
      m1_q      <= n1_q[64] ? 64'(-n1_q) : n1_q[63:0];
      den_q     <= (det_q <= 0) ? 64'd1 : det_q[63:0];
    end
  end

  // two parallel dividers on (mag<<16)/det
  logic        dv0, dv1;
  logic [79:0] q0, q1;
  dside_t      s0, s1_unused;
  dpse_udiv #(.NumW(80), .DenW(64), .BitsPerStage(4), .SideW(DSideW)) u_div0 (
    .clk_i, .rst_ni, .en_i,
    .valid_i (vd_q), .num_i ({m0_q, 16'd0}), .den_i (den_q),
    .side_i  (sd_q), .valid_o (dv0), .quot_o (q0), .side_o (s0)
  );
  dpse_udiv #(.NumW(80), .DenW(64), .BitsPerStage(4), .SideW(DSideW)) u_div1 (
    .clk_i, .rst_ni, .en_i,
    .valid_i (vd_q), .num_i ({m1_q, 16'd0}), .den_i (den_q),
    .side_i  (sd_q), .valid_o (dv1), .quot_o (q1), .side_o (s1_unused)
  );

  // stage E: signed saturated quotients
  logic               ve_q;
  dside_t             se_q;
  logic signed [31:0] x0_q, x1_q;
  logic signed [95:0] sq0, sq1;
  always_comb begin
    sq0 = (q0 > 80'h2_0000_0000) ? 96'sh2_0000_0000 : 96'(q0);
    sq1 = (q1 > 80'h2_0000_0000) ? 96'sh2_0000_0000 : 96'(q1);
    if (s0.neg0) sq0 = -sq0;
    if (s0.neg1) sq1 = -sq1;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (en_i) begin
      ve_q <= dv0 & dv1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      se_q <= s0;
      x0_q <= dpse_pkg::sat32(sq0);
      x1_q <= dpse_pkg::sat32(sq1);
    end
  end

  // stage F: flux products
  logic               vf_q;
  logic               sing_f_q;
  logic signed [31:0] x0f_q, x1f_q;
  logic signed [63:0] pu_q, po_q;
  logic signed [32:0] dx;
  assign dx = 33'(x0_q) - 33'(x1_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= ve_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sing_f_q <= se_q.sing;
      x0f_q    <= x0_q;
      x1f_q    <= x1_q;
      pu_q     <= 64'(se_q.f.flux) * ((se_q.f.flux > 0) ? 64'(x0_q) : 64'(x1_q));
      po_q     <= $signed({33'd0, se_q.f.omega}) * 64'(dx);
    end
  end

  // stage G: result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= vf_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (sing_f_q) begin
        beat_o <= '{new_fracture_conc: '0, new_matrix_conc: '0,
                    solute_flux: '0, singular_error: 1'b1};
      end else begin
        beat_o <= '{new_fracture_conc: x0f_q, new_matrix_conc: x1f_q,
                    solute_flux: dpse_pkg::sat32(96'(pu_q >>> 16) + 96'(po_q >>> 16)),
                    singular_error: 1'b0};
      end
    end
  end

`ifndef ASSERT_OFF
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni) dv0 == dv1)
    else $error("divider lanes out of step");
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && beat_o.singular_error |-> beat_o.solute_flux == 0)
    else $error("singular result carries a flux");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_o))
    else $error("pipeline moved while stalled");
`endif
endmodule

>>> sv/dual_porosity_solute_exchange.sv
// ----------------------------------------------------------------------------
// Dual-porosity solute exchange
// Per-cell fracture/matrix exchange: omega, implicit 2x2 solve, solute flux.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  (sink)   : one cell per beat (dpse_pkg::in_beat_t).
//   out_if (source) : one result per cell (dpse_pkg::out_beat_t), in order.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the seven registers while idle.
// Throughput: one cell per cycle while the pipeline is not stalled. The pipeline
//   advances as one unit through the eleven product and bookkeeping stages,
//   the two depth dividers (12 stages each) and the Cramer dividers (20 stages).
// Stall: when the output beat is not taken the whole pipeline holds, so
//   in_if.ready follows out_if.ready or an empty output slot. Nothing is
//   dropped or repeated.
// Reset: clears all valid bits and loads the register reset values
//   (shape factor, tortuosity, depth at one; diffusions at zero).
// ----------------------------------------------------------------------------
module dual_porosity_solute_exchange #(
  parameter int unsigned NUM_COMPONENTS = dpse_pkg::NumComponentsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dpse_stream_if.sink                    in_if,
  dpse_stream_if.source                  out_if,
  input  logic                           cfg_we_i,
  input  logic [dpse_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dpse_pkg::CfgDataW-1:0]  cfg_data_i
);
  logic [30:0] wr_q, tort_q, depth_q;
  logic [30:0] diff_q [NUM_COMPONENTS];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= dpse_pkg::OneQ16;
      tort_q  <= dpse_pkg::OneQ16;
      depth_q <= dpse_pkg::OneQ16;
      for (int c = 0; c < int'(NUM_COMPONENTS); c++) diff_q[c] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dpse_pkg::RegWarrenRoot) wr_q    <= cfg_data_i;
      if (cfg_idx_i == dpse_pkg::RegTortuosity) tort_q  <= cfg_data_i;
      if (cfg_idx_i == dpse_pkg::RegDepth)      depth_q <= cfg_data_i;
      for (int c = 0; c < int'(NUM_COMPONENTS); c++) begin
        if (cfg_idx_i == dpse_pkg::RegDiff0 + dpse_pkg::CfgIdxW'(c)) diff_q[c] <= cfg_data_i;
      end
    end
  end

  // whole pipeline advances when the output slot is free or being taken
  logic en;
  assign en = out_if.ready | ~out_if.valid;
  assign in_if.ready = en;

  logic               ov;
  dpse_pkg::in_beat_t ob;
  logic [30:0]        omega, omdt;

  dpse_omega #(.NumComponents(NUM_COMPONENTS)) u_omega (
    .clk_i, .rst_ni,
    .en_i      (en),
    .valid_i   (in_if.valid),
    .beat_i    (dpse_pkg::in_beat_t'(in_if.data)),
    .wr_coef_i (wr_q),
    .tort_i    (tort_q),
    .depth_i   (depth_q),
    .diff_i    (diff_q),
    .valid_o   (ov),
    .beat_o    (ob),
    .omega_o   (omega),
    .omdt_o    (omdt)
  );

  dpse_pkg::out_beat_t res;
  dpse_solve u_solve (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (ov),
    .beat_i  (ob),
    .omega_i (omega),
    .omdt_i  (omdt),
    .valid_o (out_if.valid),
    .beat_o  (res)
  );
  assign out_if.data = res;

`ifndef ASSERT_OFF
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> in_if.ready)
    else $error("input blocked with empty output");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("stalled result changed");
  a_depth_rst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> depth_q == dpse_pkg::OneQ16)
    else $error("depth reset value lost");
`endif
endmodule
